// ----- hw/rtl/mit_pkg.sv -----
// Shared types, constants and helpers of the markup item tokenizer.
`default_nettype none
package mit_pkg;

   localparam int BYTE_W           = 8;
   localparam int CFG_W            = 16;
   localparam int STATUS_W         = 4;
   localparam int OUT_POS_W        = 16;
   localparam int NAME_LEN_W       = 6;
   localparam int LEN_W            = 16;
   localparam int KW_W             = 3;
   localparam int RSP_FIELDS_W     = 2 * OUT_POS_W + NAME_LEN_W + 1;
   localparam int RSP_DATA_W       = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int FIFO_DEPTH       = 4;
   localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int MAX_NAME_LEN_DEF = 32;
   localparam int POS_BITS_DEF     = 16;

   localparam logic [CFG_W-1:0]  MAX_FIELD_LENGTH_RST = 16'd4096;
   localparam logic [KW_W-1:0]   KW_LAST              = 3'd6;
   localparam logic [LEN_W-1:0]  LEN_SAT              = 16'hFFFF;

   localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CH_LOW   = 8'd33;
   localparam logic [BYTE_W-1:0] CH_HIGH  = 8'd126;
   localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

   typedef enum logic [STATUS_W-1:0] {
      ST_ITEM           = 4'd0,
      ST_END            = 4'd1,
      ST_CLOSE_FIRST    = 4'd2,
      ST_TRUNCATED      = 4'd3,
      ST_BAD_ATTR       = 4'd4,
      ST_BAD_LENGTH     = 4'd5,
      ST_NO_GT          = 4'd6,
      ST_COUNT_MISMATCH = 4'd7,
      ST_NO_CLOSE       = 4'd8,
      ST_NAME_LONG      = 4'd9
   } status_type;

   typedef enum logic [15:0] {
      PH_SEEK     = 16'h0001,
      PH_AFTER_LT = 16'h0002,
      PH_SKIPLEAD = 16'h0004,
      PH_NAME     = 16'h0008,
      PH_ATTR_WS  = 16'h0010,
      PH_KEYWORD  = 16'h0020,
      PH_DIGITS   = 16'h0040,
      PH_COUNT    = 16'h0080,
      PH_C_LT     = 16'h0100,
      PH_C_SLASH  = 16'h0200,
      PH_C_NAME   = 16'h0400,
      PH_C_GT     = 16'h0800,
      PH_SEARCH   = 16'h1000,
      PH_U_LT     = 16'h2000,
      PH_U_NAME   = 16'h4000,
      PH_U_GT     = 16'h8000
   } phase_type;

   typedef struct packed {
      logic                    last;
      logic                    counted;
      logic [NAME_LEN_W-1:0]   name_length;
      logic [OUT_POS_W-1:0]    value_end;
      logic [OUT_POS_W-1:0]    value_start;
      status_type              status;
   } rsp_type;

   function automatic logic [BYTE_W-1:0] kw_char(input logic [KW_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         3'd0:    c = 8'h6C;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h6E;
         3'd3:    c = 8'h67;
         3'd4:    c = 8'h74;
         3'd5:    c = 8'h68;
         default: c = CH_EQ;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/markup_item_tokenizer.sv -----
// Top level of the markup item tokenizer: byte parser and result queue.
//
// Usage: document bytes enter on the req_ channel, one byte per transaction,
// req_tlast on the final byte of a document. Each byte is parsed in the cycle
// it is accepted and gives zero, one or two results, which are queued for the
// rsp_ channel; rsp_tuser carries the status, rsp_tlast marks the final result
// caused by a byte. csr_ carries max_field_length and is always ready; write it
// only while the block is idle.
// Results are written into the result queue when the byte is accepted.
// Throughput: one byte per cycle while the receiver keeps up; a byte giving
// two results queues both, which leave on rsp_ one after the other. The limit
// is the four-entry result queue, which accepts a byte whenever two entries are free.
// Reset: synchronous; returns to seeking '<' at position zero with an empty
// queue and max_field_length 4096. The tag name store is not cleared.
// Stall: with rsp_tready low, results hold in the queue and req_tready drops
// once fewer than two entries are free.
`default_nettype none
module markup_item_tokenizer
   import mit_pkg::*;
#(
   parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
   parameter int POS_BITS     = POS_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CFG_W-1:0]       csr_data,    // max_field_length
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,   // data_byte
   input  wire logic                   req_tlast,   // end_of_document
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // value_start [15:0], value_end [31:16], name_length [37:32], counted [38]
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,
   output      logic [STATUS_W-1:0]    rsp_tuser,   // status
   output      logic                   rsp_tlast    // last_result
);

   localparam int IDX_W = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
   localparam int CNT_W = $clog2(MAX_NAME_LEN + 1);
   localparam logic [CNT_W-1:0] NAME_MAX = CNT_W'(MAX_NAME_LEN);

   logic [CFG_W-1:0]     max_len_ff;
   phase_type            phase_ff, phase_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]     tag_count_ff, tag_count_in;
   logic [CNT_W-1:0]     match_ff, match_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     left_ff, left_in;
   logic [POS_BITS-1:0]  sov_ff, sov_in;
   logic [POS_BITS-1:0]  endc_ff, endc_in;
   logic [KW_W-1:0]      kw_ff, kw_in;
   logic                 stop_ff, stop_in;

   logic [BYTE_W-1:0]    tag_mem [MAX_NAME_LEN];
   logic [BYTE_W-1:0]    tag_rd_ff;
   logic                 tag_we;
   logic [IDX_W-1:0]     tag_wr_addr;
   logic [IDX_W-1:0]     tag_rd_addr;

   rsp_type              fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;

   logic                 req_acc, rsp_acc;
   logic [BYTE_W-1:0]    b;
   logic                 eod;
   logic                 err, item, item_counted;
   status_type           err_code, end_code;
   logic                 open_done, open_counted;
   logic                 name_hit;
   logic [LEN_W+3:0]     digit_sum;
   logic [POS_BITS-1:0]  ve_counted;
   logic                 has_a, has_b;
   rsp_type              res_a, res_b, wr0, wr1;
   logic [1:0]           n_wr;

   assign csr_ready = 1'b1;
   assign b         = req_tdata;
   assign eod       = req_tlast;
   assign req_tready = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign req_acc   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_acc   = rsp_tvalid && rsp_tready;

   assign name_hit  = (match_ff < tag_count_ff) && (match_ff < NAME_MAX) && (tag_rd_ff == b);
   assign digit_sum = {len_ff, 3'b000} + {2'b00, len_ff, 1'b0} + (LEN_W+4)'(b - CH_0);
   assign ve_counted = sov_ff + POS_BITS'(len_ff) - POS_BITS'(1);

   always_comb begin
      phase_in     = phase_ff;
      tag_count_in = tag_count_ff;
      match_in     = match_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      sov_in       = sov_ff;
      endc_in      = endc_ff;
      kw_in        = kw_ff;
      stop_in      = stop_ff;
      tag_we       = 1'b0;
      tag_wr_addr  = tag_count_ff[IDX_W-1:0];
      err          = 1'b0;
      err_code     = ST_ITEM;
      item         = 1'b0;
      item_counted = 1'b0;
      open_done    = 1'b0;
      open_counted = 1'b0;
      if (!stop_ff) begin
         case (phase_ff)
            PH_SEEK: begin
               if (b == CH_LT) phase_in = PH_AFTER_LT;
            end
            PH_AFTER_LT, PH_SKIPLEAD: begin
               if (phase_ff == PH_AFTER_LT && b == CH_SLASH) begin
                  err      = 1'b1;
                  err_code = ST_CLOSE_FIRST;
               end else if (!(b inside {[CH_LOW:CH_HIGH]})) begin
                  phase_in = PH_SKIPLEAD;
               end else begin
                  tag_we       = 1'b1;
                  tag_wr_addr  = '0;
                  tag_count_in = CNT_W'(1);
                  phase_in     = PH_NAME;
               end
            end
            PH_NAME: begin
               if (b == CH_GT) begin
                  open_done = 1'b1;
               end else if (b inside {CH_SPACE, CH_TAB}) begin
                  phase_in = PH_ATTR_WS;
               end else if (tag_count_ff >= NAME_MAX) begin
                  err      = 1'b1;
                  err_code = ST_NAME_LONG;
               end else begin
                  tag_we       = 1'b1;
                  tag_count_in = tag_count_ff + CNT_W'(1);
               end
            end
            PH_ATTR_WS: begin
               if (b inside {CH_SPACE, CH_TAB}) begin
                  phase_in = PH_ATTR_WS;
               end else if (b == CH_GT) begin
                  open_done = 1'b1;
               end else if ((b | CASE_BIT) == kw_char('0)) begin
                  kw_in    = KW_W'(1);
                  phase_in = PH_KEYWORD;
               end else begin
                  err      = 1'b1;
                  err_code = ST_BAD_ATTR;
               end
            end
            PH_KEYWORD: begin
               if (kw_ff >= KW_LAST) begin
                  if (b == CH_EQ) begin
                     kw_in    = '0;
                     len_in   = '0;
                     phase_in = PH_DIGITS;
                  end else begin
                     err      = 1'b1;
                     err_code = ST_BAD_ATTR;
                  end
               end else if ((b | CASE_BIT) == kw_char(kw_ff)) begin
                  kw_in = kw_ff + KW_W'(1);
               end else begin
                  err      = 1'b1;
                  err_code = ST_BAD_ATTR;
               end
            end
            PH_DIGITS: begin
               if (b inside {[CH_0:CH_9]}) begin
                  len_in = (digit_sum > (LEN_W+4)'(LEN_SAT)) ? LEN_SAT : digit_sum[LEN_W-1:0];
                  kw_in  = KW_W'(1);
               end else if (kw_ff == '0) begin
                  err      = 1'b1;
                  err_code = ST_BAD_LENGTH;
               end else if (len_ff == '0 || len_ff >= max_len_ff) begin
                  err      = 1'b1;
                  err_code = ST_BAD_LENGTH;
               end else if (b != CH_GT) begin
                  err      = 1'b1;
                  err_code = ST_NO_GT;
               end else begin
                  open_done    = 1'b1;
                  open_counted = 1'b1;
               end
            end
            PH_COUNT: begin
               if (left_ff <= LEN_W'(1)) begin
                  left_in  = '0;
                  phase_in = PH_C_LT;
               end else begin
                  left_in = left_ff - LEN_W'(1);
               end
            end
            PH_C_LT: begin
               if (b == CH_LT) begin
                  phase_in = PH_C_SLASH;
               end else begin
                  err      = 1'b1;
                  err_code = ST_COUNT_MISMATCH;
               end
            end
            PH_C_SLASH: begin
               if (b == CH_SLASH) begin
                  match_in = '0;
                  phase_in = PH_C_NAME;
               end else begin
                  err      = 1'b1;
                  err_code = ST_COUNT_MISMATCH;
               end
            end
            PH_C_NAME: begin
               if (name_hit) begin
                  match_in = match_ff + CNT_W'(1);
                  if (match_in >= tag_count_ff) phase_in = PH_C_GT;
               end else begin
                  err      = 1'b1;
                  err_code = ST_COUNT_MISMATCH;
               end
            end
            PH_C_GT: begin
               if (b == CH_GT) begin
                  item         = 1'b1;
                  item_counted = 1'b1;
               end else begin
                  err      = 1'b1;
                  err_code = ST_COUNT_MISMATCH;
               end
            end
            PH_SEARCH: begin
               if (b == CH_LT) phase_in = PH_U_LT;
            end
            PH_U_LT: begin
               if (b == CH_SLASH) begin
                  endc_in  = pos_ff - POS_BITS'(2);
                  match_in = '0;
                  phase_in = PH_U_NAME;
               end else begin
                  phase_in = (b == CH_LT) ? PH_U_LT : PH_SEARCH;
               end
            end
            PH_U_NAME: begin
               if (name_hit) begin
                  match_in = match_ff + CNT_W'(1);
                  if (match_in >= tag_count_ff) phase_in = PH_U_GT;
               end else begin
                  phase_in = (b == CH_LT) ? PH_U_LT : PH_SEARCH;
               end
            end
            PH_U_GT: begin
               if (b == CH_GT) begin
                  item = 1'b1;
               end else begin
                  phase_in = (b == CH_LT) ? PH_U_LT : PH_SEARCH;
               end
            end
            default: phase_in = PH_SEEK;
         endcase
      end

      if (open_done) begin
         sov_in = pos_ff + POS_BITS'(1);
         if (open_counted) begin
            left_in  = len_ff;
            phase_in = PH_COUNT;
         end else begin
            phase_in = PH_SEARCH;
         end
      end

      if (err) stop_in = 1'b1;
      else if (item) phase_in = PH_SEEK;

      if (stop_ff) end_code = ST_END;
      else begin
         case (phase_in)
            PH_SEEK:     end_code = ST_END;
            PH_KEYWORD:  end_code = ST_BAD_ATTR;
            PH_AFTER_LT, PH_SKIPLEAD, PH_NAME, PH_ATTR_WS, PH_DIGITS:
                         end_code = ST_TRUNCATED;
            default:     end_code = ST_NO_CLOSE;
         endcase
      end

      if (eod) begin
         phase_in = PH_SEEK;
         stop_in  = 1'b0;
         pos_in   = '0;
      end else begin
         pos_in = pos_ff + POS_BITS'(1);
      end
   end

   always_comb begin
      has_a = err || item;
      has_b = eod && !err;

      res_a             = '0;
      res_a.last        = !has_b;
      if (err) begin
         res_a.status = err_code;
      end else begin
         res_a.status      = ST_ITEM;
         res_a.value_start = OUT_POS_W'(sov_ff);
         res_a.value_end   = item_counted ? OUT_POS_W'(ve_counted) : OUT_POS_W'(endc_ff);
         res_a.name_length = NAME_LEN_W'(tag_count_ff);
         res_a.counted     = item_counted;
      end

      res_b        = '0;
      res_b.status = end_code;
      res_b.last   = 1'b1;

      wr0  = has_a ? res_a : res_b;
      wr1  = res_b;
      n_wr = {1'b0, has_a} + {1'b0, has_b};
   end

   assign tag_rd_addr = req_acc ? match_in[IDX_W-1:0] : match_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (req_acc && tag_we) tag_mem[tag_wr_addr] <= b;
      tag_rd_ff <= tag_mem[tag_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_FIELD_LENGTH_RST;
         phase_ff     <= PH_SEEK;
         pos_ff       <= '0;
         tag_count_ff <= '0;
         match_ff     <= '0;
         len_ff       <= '0;
         left_ff      <= '0;
         sov_ff       <= '0;
         endc_ff      <= '0;
         kw_ff        <= '0;
         stop_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) max_len_ff <= csr_data;
         if (req_acc) begin
            phase_ff     <= phase_in;
            pos_ff       <= pos_in;
            tag_count_ff <= tag_count_in;
            match_ff     <= match_in;
            len_ff       <= len_in;
            left_ff      <= left_in;
            sov_ff       <= sov_in;
            endc_ff      <= endc_in;
            kw_ff        <= kw_in;
            stop_ff      <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && n_wr != 2'd0) fifo_mem[wr_ptr_ff] <= wr0;
      if (req_acc && n_wr == 2'd2) fifo_mem[wr_ptr_ff + FIFO_PTR_W'(1)] <= wr1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_acc) wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(n_wr);
         if (rsp_acc) rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         count_ff <= count_ff + (req_acc ? FIFO_CNT_W'(n_wr) : '0)
                     - (rsp_acc ? FIFO_CNT_W'(1) : '0);
      end
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[OUT_POS_W-1:0]               = fifo_mem[rd_ptr_ff].value_start;
      rsp_tdata[2*OUT_POS_W-1:OUT_POS_W]     = fifo_mem[rd_ptr_ff].value_end;
      rsp_tdata[2*OUT_POS_W+NAME_LEN_W-1:2*OUT_POS_W] = fifo_mem[rd_ptr_ff].name_length;
      rsp_tdata[2*OUT_POS_W+NAME_LEN_W]      = fifo_mem[rd_ptr_ff].counted;
   end

   assign rsp_tuser = fifo_mem[rd_ptr_ff].status;
   assign rsp_tlast = fifo_mem[rd_ptr_ff].last;

endmodule
`default_nettype wire

// ----- hw/rtl/mit_checker.sv -----
// Port-level checker for the markup item tokenizer, with its bind.
`default_nettype none
module mit_checker
   import mit_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [STATUS_W-1:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("queue not empty after reset");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= STATUS_W'(ST_NAME_LONG))
      else $error("status code out of range");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_W'(ST_ITEM) |-> rsp_tdata == '0)
      else $error("non-item result carries data");

endmodule

bind markup_item_tokenizer mit_checker u_mit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ----- tb/sv/markup_item_tokenizer_test.sv -----
// Self-checking testbench of the markup item tokenizer: byte stream in, item reports out.
module markup_item_tokenizer_test;
   import mit_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_NAME     = MAX_NAME_LEN_DEF;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [BYTE_W-1:0] KEYWORD [6] = '{"l", "e", "n", "g", "t", "h"};
   localparam logic [BYTE_W-1:0] NOISE_BYTES [7] =
      '{CH_LT, CH_SLASH, CH_GT, CH_SPACE, "l", CH_EQ, "3"};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   markup_item_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // parser state mirrored from the block
   phase_type         parse_phase = PH_SEEK;
   logic [15:0]       doc_pos = '0;
   logic [BYTE_W-1:0] name_bytes [MAX_NAME];
   logic [5:0]        name_len = '0;
   logic [5:0]        match_count = '0;
   logic [15:0]       length_acc = '0;
   logic [15:0]       count_left = '0;
   logic [15:0]       value_first = '0;
   logic [15:0]       close_guess = '0;
   logic [2:0]        kw_pos = '0;
   bit                halted = 1'b0;
   logic [CFG_W-1:0]  field_limit = MAX_FIELD_LENGTH_RST;

   rsp_type           expected_tokens [$];
   logic [BYTE_W-1:0] doc_bytes [$];

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   bit hold_request    = 1'b0;
   int failures        = 0;
   int bytes_sent      = 0;
   int docs_sent       = 0;
   int limit_writes    = 0;
   int results_checked = 0;
   int items_seen      = 0;
   int ends_seen       = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic phase_type rescan_phase(input logic [BYTE_W-1:0] b);
      return (b == CH_LT) ? PH_U_LT : PH_SEARCH;
   endfunction

   task automatic open_value(input bit counted);
      value_first = doc_pos + 16'd1;
      if (counted) begin
         count_left  = length_acc;
         parse_phase = PH_COUNT;
      end else begin
         parse_phase = PH_SEARCH;
      end
   endtask

   // advance the parser by one byte and queue the results it gives
   task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic eod);
      status_type  fault;
      status_type  closing;
      rsp_type     res [2];
      int          n;
      bit          found;
      bit          found_counted;
      bit          was_halted;
      logic [31:0] acc;
      fault = ST_ITEM;
      found = 1'b0;
      found_counted = 1'b0;
      was_halted = halted;
      n = 0;
      if (!was_halted) begin
         case (parse_phase)
            PH_SEEK: begin
               if (b == CH_LT) parse_phase = PH_AFTER_LT;
            end
            PH_AFTER_LT, PH_SKIPLEAD: begin
               if (parse_phase == PH_AFTER_LT && b == CH_SLASH) begin
                  fault = ST_CLOSE_FIRST;
               end else if (b < CH_LOW || b > CH_HIGH) begin
                  parse_phase = PH_SKIPLEAD;
               end else begin
                  name_bytes[0] = b;
                  name_len = 6'd1;
                  parse_phase = PH_NAME;
               end
            end
            PH_NAME: begin
               if (b == CH_GT) begin
                  open_value(1'b0);
               end else if (b == CH_SPACE || b == CH_TAB) begin
                  parse_phase = PH_ATTR_WS;
               end else if (name_len >= MAX_NAME) begin
                  fault = ST_NAME_LONG;
               end else begin
                  name_bytes[name_len] = b;
                  name_len++;
               end
            end
            PH_ATTR_WS: begin
               if (b == CH_GT) begin
                  open_value(1'b0);
               end else if ((b | CASE_BIT) == KEYWORD[0]) begin
                  kw_pos = 3'd1;
                  parse_phase = PH_KEYWORD;
               end else if (b != CH_SPACE && b != CH_TAB) begin
                  fault = ST_BAD_ATTR;
               end
            end
            PH_KEYWORD: begin
               if (kw_pos >= 3'd6) begin
                  if (b == CH_EQ) begin
                     kw_pos = '0;
                     length_acc = '0;
                     parse_phase = PH_DIGITS;
                  end else begin
                     fault = ST_BAD_ATTR;
                  end
               end else if ((b | CASE_BIT) == KEYWORD[kw_pos]) begin
                  kw_pos++;
               end else begin
                  fault = ST_BAD_ATTR;
               end
            end
            PH_DIGITS: begin
               if (b >= CH_0 && b <= CH_9) begin
                  acc = 32'(length_acc) * 32'd10 + 32'(b - CH_0);
                  length_acc = (acc > 32'hFFFF) ? 16'hFFFF : acc[15:0];
                  kw_pos = 3'd1;
               end else if (kw_pos == 0 || length_acc == 0 || length_acc >= field_limit) begin
                  fault = ST_BAD_LENGTH;
               end else if (b != CH_GT) begin
                  fault = ST_NO_GT;
               end else begin
                  open_value(1'b1);
               end
            end
            PH_COUNT: begin
               if (count_left <= 16'd1) begin
                  count_left = '0;
                  parse_phase = PH_C_LT;
               end else begin
                  count_left--;
               end
            end
            PH_C_LT: begin
               if (b == CH_LT) parse_phase = PH_C_SLASH;
               else fault = ST_COUNT_MISMATCH;
            end
            PH_C_SLASH: begin
               if (b == CH_SLASH) begin
                  match_count = '0;
                  parse_phase = PH_C_NAME;
               end else begin
                  fault = ST_COUNT_MISMATCH;
               end
            end
            PH_C_NAME: begin
               if (match_count < name_len && name_bytes[match_count] == b) begin
                  match_count++;
                  if (match_count >= name_len) parse_phase = PH_C_GT;
               end else begin
                  fault = ST_COUNT_MISMATCH;
               end
            end
            PH_C_GT: begin
               if (b == CH_GT) begin
                  found = 1'b1;
                  found_counted = 1'b1;
               end else begin
                  fault = ST_COUNT_MISMATCH;
               end
            end
            PH_SEARCH: begin
               if (b == CH_LT) parse_phase = PH_U_LT;
            end
            PH_U_LT: begin
               if (b == CH_SLASH) begin
                  close_guess = doc_pos - 16'd2;
                  match_count = '0;
                  parse_phase = PH_U_NAME;
               end else begin
                  parse_phase = rescan_phase(b);
               end
            end
            PH_U_NAME: begin
               if (match_count < name_len && name_bytes[match_count] == b) begin
                  match_count++;
                  if (match_count >= name_len) parse_phase = PH_U_GT;
               end else begin
                  parse_phase = rescan_phase(b);
               end
            end
            default: begin
               if (b == CH_GT) found = 1'b1;
               else parse_phase = rescan_phase(b);
            end
         endcase
      end

      if (fault != ST_ITEM) begin
         res[n] = '0;
         res[n].status = fault;
         n++;
         halted = 1'b1;
      end else if (found) begin
         res[n] = '0;
         res[n].status = ST_ITEM;
         res[n].value_start = value_first;
         res[n].value_end = found_counted ? value_first + length_acc - 16'd1 : close_guess;
         res[n].name_length = name_len;
         res[n].counted = found_counted;
         n++;
         parse_phase = PH_SEEK;
      end

      if (eod) begin
         if (fault == ST_ITEM) begin
            if (was_halted || parse_phase == PH_SEEK) closing = ST_END;
            else if (parse_phase == PH_KEYWORD) closing = ST_BAD_ATTR;
            else if (parse_phase inside {PH_AFTER_LT, PH_SKIPLEAD, PH_NAME, PH_ATTR_WS,
                                         PH_DIGITS}) closing = ST_TRUNCATED;
            else closing = ST_NO_CLOSE;
            res[n] = '0;
            res[n].status = closing;
            n++;
         end
         parse_phase = PH_SEEK;
         halted = 1'b0;
         doc_pos = '0;
      end else begin
         doc_pos++;
      end

      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_tokens.push_back(res[i]);
   endtask

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         failures++;
      end
   endtask

   // result checking and prediction, sampled at the rising edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (rsp_tuser == ST_ITEM) items_seen++;
            if (rsp_tuser == ST_END) ends_seen++;
            if (expected_tokens.size() == 0) begin
               $display("%0t: result with nothing expected, status %0d, data %0h",
                        $time, rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_tuser));
               check_field("value_start", want.value_start, rsp_tdata[OUT_POS_W-1:0]);
               check_field("value_end", want.value_end, rsp_tdata[2*OUT_POS_W-1:OUT_POS_W]);
               check_field("name_length", 16'(want.name_length),
                           16'(rsp_tdata[2*OUT_POS_W+NAME_LEN_W-1:2*OUT_POS_W]));
               check_field("counted", 16'(want.counted),
                           16'(rsp_tdata[2*OUT_POS_W+NAME_LEN_W]));
               check_field("last", 16'(want.last), 16'(rsp_tlast));
            end
         end
         if (csr_valid && csr_ready) field_limit = csr_data;
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
      end
   end

   // receiver: random stalls, or a long counted hold-off on request
   initial begin : receiver
      int held;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) begin
               rsp_tready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_tokens.size());
      $display("markup_item_tokenizer_test failed");
      $finish;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_doc();
      for (int i = 0; i < doc_bytes.size(); i++) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
      docs_sent++;
      doc_bytes.delete();
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      add_text(s);
      send_doc();
   endtask

   // drop valid, drain the expected results, then let the pipeline settle
   task automatic wait_idle(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic program_limit(input logic [CFG_W-1:0] value);
      wait_idle(4);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      limit_writes++;
   endtask

   function automatic int pick_count();
      int lim;
      int r;
      lim = int'(field_limit) - 1;
      r = $urandom_range(99);
      if (r < 4) return 0;
      if (r < 8) return lim + 1;
      if (r < 10) return 70000;
      if (lim < 1) return $urandom_range(1, 3);
      if (r < 18 && lim <= 64) return lim;
      return $urandom_range(1, lim < 8 ? lim : 8);
   endfunction

   task automatic add_filler(input int n);
      logic [BYTE_W-1:0] c;
      repeat (n) begin
         c = 8'($urandom_range(255));
         doc_bytes.push_back(c == CH_LT ? CH_GT : c);
      end
   endtask

   task automatic add_item();
      logic [BYTE_W-1:0] nm [$];
      logic [BYTE_W-1:0] c;
      int                nlen;
      int                n;
      int                r;
      int                cut;
      int                first;
      string             digits;
      first = doc_bytes.size();
      r = $urandom_range(99);
      nlen = (r < 70) ? $urandom_range(1, 3) : (r < 94) ? $urandom_range(4, 12) :
             (r < 98) ? MAX_NAME : MAX_NAME + 1;
      doc_bytes.push_back(CH_LT);
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 2))
            doc_bytes.push_back($urandom_range(1) ? 8'($urandom_range(0, 32))
                                                  : 8'($urandom_range(127, 255)));
      for (int i = 0; i < nlen; i++) begin
         do c = 8'($urandom_range(33, 126)); while (c == CH_GT || (i == 0 && c == CH_SLASH));
         nm.push_back(c);
         doc_bytes.push_back(c);
      end
      if ($urandom_range(1)) begin
         repeat ($urandom_range(1, 2)) doc_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
         for (int k = 0; k < 6; k++)
            doc_bytes.push_back($urandom_range(1) ? KEYWORD[k] : (KEYWORD[k] & ~CASE_BIT));
         doc_bytes.push_back(CH_EQ);
         n = pick_count();
         digits = $sformatf("%0d", n);
         if ($urandom_range(9) == 0) digits = {"0", digits};
         add_text(digits);
         doc_bytes.push_back(CH_GT);
         repeat (n > 40 ? 40 : n) doc_bytes.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(3) == 0) doc_bytes.push_back(CH_SPACE);
         doc_bytes.push_back(CH_GT);
         repeat ($urandom_range(0, 6)) doc_bytes.push_back(8'($urandom_range(255)));
      end
      doc_bytes.push_back(CH_LT);
      doc_bytes.push_back(CH_SLASH);
      foreach (nm[i]) doc_bytes.push_back(nm[i]);
      doc_bytes.push_back(CH_GT);
      // corrupt one byte or cut the item short
      if ($urandom_range(99) < 12) begin
         cut = $urandom_range(first + 1, doc_bytes.size() - 1);
         if ($urandom_range(1)) doc_bytes[cut] = 8'($urandom_range(255));
         else doc_bytes = doc_bytes[0:cut-1];
      end
   endtask

   task automatic add_noise();
      int r;
      repeat ($urandom_range(1, 12)) begin
         r = $urandom_range(7);
         doc_bytes.push_back(r == 7 ? 8'($urandom_range(255)) : NOISE_BYTES[r]);
      end
   endtask

   task automatic send_random_doc();
      if ($urandom_range(9) == 0) begin
         add_noise();
      end else begin
         add_filler($urandom_range(0, 2));
         repeat ($urandom_range(1, 3)) begin
            add_item();
            add_filler($urandom_range(0, 2));
         end
         if ($urandom_range(9) == 0 && doc_bytes.size() > 5)
            doc_bytes = doc_bytes[0:doc_bytes.size()-1-$urandom_range(1, 4)];
      end
      send_doc();
   endtask

   task automatic test_item_framing();
      send_text("<a>x</a>");
      doc_bytes = '{CH_LT, 8'h00, 8'hFF, CH_SPACE, 8'h7F, 8'h80};
      add_text("ab\tLeNgTh=3>x<y</ab>");
      send_doc();
      send_text("<q></q> ");
      send_text("<a><a>x</a></a>");
      send_text("<ab >z</a<</ab>");
      send_text("< /b>x<//b>");
   endtask

   task automatic test_document_end();
      send_text("x");
      send_text("<ab");
      send_text("<a le");
      send_text("<a length");
      send_text("<a length=");
      send_text("<a>xx");
      send_text("<a length=4>ab");
      send_text("</");
   endtask

   task automatic test_parse_errors();
      send_text("</x>abc");
      send_text("<a x>");
      send_text("<a lx");
      send_text("<a length+");
      send_text("<a length=>");
      send_text("<a length=0>");
      send_text("<a length=99999>");
      send_text("<a length=4096>");
      send_text("<a length=2 ");
      send_text("<a length=1>xy");
      send_text("<a length=1>x</b>");
      send_text("<a length=1>x<x");
      send_text("<a length=1>x</a!");
   endtask

   task automatic test_long_names();
      string kname;
      kname = "";
      repeat (MAX_NAME) kname = {kname, "k"};
      send_text({"<", kname, ">v</", kname, ">"});
      send_text({"<", kname, "kk>"});
   endtask

   task automatic test_length_register();
      program_limit(16'hFFFF);
      send_text("<a length=65534>xy");
      send_text("<a length=65535>");
      program_limit(16'd1);
      send_text("<a length=1>x</a>");
      program_limit(16'd10);
      send_text("<b length=9>123456789</b>");
      send_text("<b length=10>");
      program_limit(MAX_FIELD_LENGTH_RST);
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input logic [CFG_W-1:0] limit, input int n_bytes);
      int target;
      program_limit(limit);
      sender_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) send_random_doc();
   endtask

   task automatic test_backpressure();
      int target;
      program_limit(16'd12);
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 1'b1;
      target = bytes_sent + 150;
      while (bytes_sent < target) send_random_doc();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_item_framing();
      test_document_end();
      test_parse_errors();
      test_long_names();
      test_length_register();
      test_random_traffic(0, 0, MAX_FIELD_LENGTH_RST, 310);
      test_random_traffic(87, 0, 16'd5, 290);
      test_random_traffic(0, 87, 16'hFFFF, 290);
      test_random_traffic(14, 14, 16'($urandom_range(2, 40)), 290);
      test_backpressure();
      wait_idle(8);
      $display("sent %0d bytes in %0d documents across %0d length limits, with idle, stall",
               bytes_sent, docs_sent, limit_writes);
      $display("and hold-off phases; checked %0d results: %0d items, %0d ends, %0d errors",
               results_checked, items_seen, ends_seen, results_checked - items_seen - ends_seen);
      if (failures == 0) $display("markup_item_tokenizer_test passed");
      else $display("markup_item_tokenizer_test failed");
      $finish;
   end

endmodule
